// ===== design/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg
// Types and constants shared by the sample ring report aggregator modules.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned REP_S_W  = 16;
    localparam int unsigned OBS_S_W  = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] INVALID_MARK  = 16'hFFFF;
    localparam logic [15:0]         GOOD_QUALITY  = 16'd100;
    localparam logic [PCT_W-1:0]    PCT_SCALE     = 7'd100;
    localparam logic [10:0]         TWICE_MS_PER_S = 11'd2000;
    localparam logic [DELAY_W-1:0]  DELAY_RESET   = 16'd1000;
    localparam logic [PCT_W-1:0]    PCT_RESET     = 7'd90;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACQ_DELAY  = 2'd0,
        CFG_SAMPLE_PCT = 2'd1,
        CFG_OBS_PCT    = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INST_RD, ST_INST_SET,
        ST_REP_GO, ST_REP_WAIT, ST_OBS_GO, ST_OBS_WAIT, ST_EXP_GO, ST_EXP_WAIT,
        ST_WALK_RD, ST_WALK_ACC, ST_WIN_CHK, ST_WIN_GO, ST_WIN_WAIT,
        ST_FIN_CHK, ST_FIN_GO, ST_FIN_WAIT, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        DSEL_REP, DSEL_OBS, DSEL_EXP, DSEL_WIN, DSEL_FIN
    } div_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     rd_en;
        logic     acc;
        logic     win_accept_zero;
        logic     win_accept_quot;
        logic     win_reject;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     set_inst;
        logic     set_invalid;
        logic     set_valid_zero;
        logic     set_valid_quot;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_report;
        logic rep_zero_in;
        logic div_done;
        logic obs_zero;
        logic walk_more;
        logic win_close;
        logic win_ok;
        logic win_any;
        logic fin_ok;
        logic acc_any;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/sra_div.sv =====
// ----------------------------------------------------------------------------
// sra_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sra_div #(
    parameter int unsigned DIVIDEND_W = 28,
    parameter int unsigned DIVISOR_W  = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVIDEND_W);
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
                rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/sra_datapath.sv =====
// ----------------------------------------------------------------------------
// sra_datapath
// Sample ring, configuration registers, report accumulators and result slot.
// ----------------------------------------------------------------------------
module sra_datapath #(
    parameter int unsigned RING_DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tuser,
    input  logic [47:0]                  s_tdata,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [39:0]                  m_tdata,
    input  sra_pkg::ctrl_cmd_t           ctl,
    output sra_pkg::dp_status_t          sts
);

    localparam int unsigned IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int unsigned SUM_W  = sra_pkg::SAMPLE_W + CNT_W;
    localparam int unsigned DIV_W  = (SUM_W > 28) ? SUM_W : 28;
    localparam int unsigned DVS_W  = (CNT_W > 17) ? CNT_W : 17;
    localparam int unsigned CMP_W  = (CNT_W > 16) ? CNT_W : 16;
    localparam int unsigned PW     = CMP_W + sra_pkg::PCT_W;

    // Configuration.
    logic [15:0] acq_delay_reg;
    logic [6:0]  sample_pct_reg;
    logic [6:0]  obs_pct_reg;

    // Ring bookkeeping.
    logic [16:0]      ring_mem [RING_DEPTH];
    logic [16:0]      rd_data_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    logic [CNT_W-1:0] stored_reg;
    logic [IDX_W-1:0] newest_idx;

    // Report work registers.
    logic [15:0]      rep_s_reg;
    logic [7:0]       obs_s_reg;
    logic [15:0]      rep_cnt_reg;
    logic [15:0]      obs_cnt_reg;
    logic [15:0]      exp_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] win_total_reg;
    logic [CNT_W-1:0] win_valid_reg;
    logic [SUM_W-1:0] win_sum_reg;
    logic [CNT_W-1:0] accepted_reg;
    logic [SUM_W-1:0] obs_sum_reg;
    logic [15:0]      res_mean_reg;
    logic [15:0]      res_quality_reg;
    logic             res_valid_reg;
    logic             out_valid_reg;
    logic [15:0]      out_mean_reg;
    logic [15:0]      out_quality_reg;
    logic             out_rv_reg;

    logic             in_accept;
    logic             push;
    logic             report;
    logic [15:0]      in_sample;
    logic             in_maint;
    logic [15:0]      in_rep;
    logic [7:0]       in_obs;
    logic [15:0]      delay_eff;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quot;
    logic             div_busy;
    logic             div_done;
    logic [15:0]      quot_sat;
    logic [15:0]      rd_sample;
    logic             rd_good;

    assign in_accept = s_tvalid && ctl.in_ready;
    assign push      = in_accept && !s_tuser;
    assign report    = in_accept && s_tuser;
    assign in_sample = s_tdata[15:0];
    assign in_maint  = s_tdata[16];
    assign in_rep    = s_tdata[32:17];
    assign in_obs    = s_tdata[40:33];

    assign newest_idx = (wr_idx_reg == '0) ? IDX_W'(RING_DEPTH - 1) : wr_idx_reg - IDX_W'(1);
    assign delay_eff  = (acq_delay_reg == '0) ? 16'd1 : acq_delay_reg;
    assign rd_sample  = rd_data_reg[15:0];
    assign rd_good    = (rd_sample != sra_pkg::INVALID_MARK) && !rd_data_reg[16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acq_delay_reg  <= sra_pkg::DELAY_RESET;
            sample_pct_reg <= sra_pkg::PCT_RESET;
            obs_pct_reg    <= sra_pkg::PCT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                sra_pkg::CFG_ACQ_DELAY:  acq_delay_reg  <= cfg_data;
                sra_pkg::CFG_SAMPLE_PCT: sample_pct_reg <= cfg_data[6:0];
                sra_pkg::CFG_OBS_PCT:    obs_pct_reg    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ring_mem[wr_idx_reg] <= {in_maint, in_sample};
        end
        if (ctl.rd_en) begin
            rd_data_reg <= ring_mem[idx_reg];
        end
    end

    always_comb begin
        div_dividend = '0;
        div_divisor  = '0;
        case (ctl.div_sel)
            sra_pkg::DSEL_REP: begin
                div_dividend = DIV_W'(rep_s_reg) * DIV_W'(sra_pkg::TWICE_MS_PER_S)
                               + DIV_W'(delay_eff);
                div_divisor  = DVS_W'({delay_eff, 1'b0});
            end
            sra_pkg::DSEL_OBS: begin
                div_dividend = DIV_W'(obs_s_reg) * DIV_W'(sra_pkg::TWICE_MS_PER_S)
                               + DIV_W'(delay_eff);
                div_divisor  = DVS_W'({delay_eff, 1'b0});
            end
            sra_pkg::DSEL_EXP: begin
                div_dividend = DIV_W'(rep_cnt_reg);
                div_divisor  = DVS_W'(obs_cnt_reg);
            end
            sra_pkg::DSEL_WIN: begin
                div_dividend = DIV_W'(win_sum_reg);
                div_divisor  = DVS_W'(win_valid_reg);
            end
            sra_pkg::DSEL_FIN: begin
                div_dividend = DIV_W'(obs_sum_reg);
                div_divisor  = DVS_W'(accepted_reg);
            end
            default: ;
        endcase
    end

    sra_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign quot_sat = (div_quot[DIV_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg      <= '0;
            stored_reg      <= '0;
            rep_s_reg       <= '0;
            obs_s_reg       <= '0;
            rep_cnt_reg     <= '0;
            obs_cnt_reg     <= '0;
            exp_reg         <= '0;
            idx_reg         <= '0;
            n_reg           <= '0;
            win_total_reg   <= '0;
            win_valid_reg   <= '0;
            win_sum_reg     <= '0;
            accepted_reg    <= '0;
            obs_sum_reg     <= '0;
            res_mean_reg    <= '0;
            res_quality_reg <= '0;
            res_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_mean_reg    <= '0;
            out_quality_reg <= '0;
            out_rv_reg      <= 1'b0;
        end else begin
            if (push) begin
                wr_idx_reg <= (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                              : wr_idx_reg + IDX_W'(1);
                if (stored_reg != CNT_W'(RING_DEPTH)) begin
                    stored_reg <= stored_reg + CNT_W'(1);
                end
            end
            if (report) begin
                rep_s_reg     <= in_rep;
                obs_s_reg     <= in_obs;
                exp_reg       <= '0;
                idx_reg       <= newest_idx;
                n_reg         <= '0;
                win_total_reg <= '0;
                win_valid_reg <= '0;
                win_sum_reg   <= '0;
                accepted_reg  <= '0;
                obs_sum_reg   <= '0;
            end
            if (ctl.div_store) begin
                case (ctl.div_sel)
                    sra_pkg::DSEL_REP: rep_cnt_reg <= quot_sat;
                    sra_pkg::DSEL_OBS: obs_cnt_reg <= quot_sat;
                    sra_pkg::DSEL_EXP: exp_reg     <= div_quot[15:0];
                    default: ;
                endcase
            end
            if (ctl.acc) begin
                idx_reg       <= (idx_reg == '0) ? IDX_W'(RING_DEPTH - 1) : idx_reg - IDX_W'(1);
                n_reg         <= n_reg + CNT_W'(1);
                win_total_reg <= win_total_reg + CNT_W'(1);
                if (rd_good) begin
                    win_valid_reg <= win_valid_reg + CNT_W'(1);
                    win_sum_reg   <= win_sum_reg + SUM_W'(rd_sample);
                end
            end
            if (ctl.win_accept_zero || ctl.win_accept_quot || ctl.win_reject) begin
                win_total_reg <= '0;
                win_valid_reg <= '0;
                win_sum_reg   <= '0;
            end
            if (ctl.win_accept_zero || ctl.win_accept_quot) begin
                accepted_reg <= accepted_reg + CNT_W'(1);
            end
            if (ctl.win_accept_quot) begin
                obs_sum_reg <= obs_sum_reg + SUM_W'(div_quot[15:0]);
            end
            if (ctl.set_inst) begin
                res_mean_reg    <= (stored_reg == '0) ? sra_pkg::INVALID_MARK : rd_sample;
                res_quality_reg <= sra_pkg::INVALID_MARK;
                res_valid_reg   <= 1'b0;
            end
            if (ctl.set_invalid) begin
                res_mean_reg    <= sra_pkg::INVALID_MARK;
                res_quality_reg <= sra_pkg::INVALID_MARK;
                res_valid_reg   <= 1'b0;
            end
            if (ctl.set_valid_zero) begin
                res_mean_reg    <= '0;
                res_quality_reg <= sra_pkg::GOOD_QUALITY;
                res_valid_reg   <= 1'b1;
            end
            if (ctl.set_valid_quot) begin
                res_mean_reg    <= div_quot[15:0];
                res_quality_reg <= sra_pkg::GOOD_QUALITY;
                res_valid_reg   <= 1'b1;
            end
            if (ctl.out_load) begin
                out_valid_reg   <= 1'b1;
                out_mean_reg    <= res_mean_reg;
                out_quality_reg <= res_quality_reg;
                out_rv_reg      <= res_valid_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.in_report   = s_tvalid && s_tuser;
        sts.rep_zero_in = (in_rep == '0);
        sts.div_done    = div_done;
        sts.obs_zero    = (obs_cnt_reg == '0);
        sts.walk_more   = (CMP_W'(n_reg) < CMP_W'(stored_reg))
                          && (CMP_W'(n_reg) < CMP_W'(rep_cnt_reg));
        sts.win_close   = (CMP_W'(win_total_reg) == CMP_W'(obs_cnt_reg));
        sts.win_ok      = (PW'(win_valid_reg) * PW'(sra_pkg::PCT_SCALE))
                          >= (PW'(sample_pct_reg) * PW'(win_total_reg));
        sts.win_any     = (win_valid_reg != '0);
        sts.fin_ok      = (exp_reg != '0)
                          && ((PW'(accepted_reg) * PW'(sra_pkg::PCT_SCALE))
                              >= (PW'(obs_pct_reg) * PW'(exp_reg)));
        sts.acc_any     = (accepted_reg != '0);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_rv_reg, out_quality_reg, out_mean_reg};

`ifndef SYNTH
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_stored_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= CNT_W'(RING_DEPTH))
        else $error("stored count above ring depth");
    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        win_total_reg <= n_reg)
        else $error("window longer than the walk");
    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!out_valid_reg || m_tready))
        else $error("result slot overwritten");
`endif

endmodule

// ===== design/sra_ctrl.sv =====
// ----------------------------------------------------------------------------
// sra_ctrl
// Sequencer that steps the datapath through one report.
// ----------------------------------------------------------------------------
module sra_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  sra_pkg::dp_status_t sts,
    output sra_pkg::ctrl_cmd_t  ctl
);

    sra_pkg::state_t state_reg;
    sra_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sra_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sra_pkg::ST_IDLE: begin
                if (sts.in_report) begin
                    state_next = sts.rep_zero_in ? sra_pkg::ST_INST_RD : sra_pkg::ST_REP_GO;
                end
            end
            sra_pkg::ST_INST_RD:  state_next = sra_pkg::ST_INST_SET;
            sra_pkg::ST_INST_SET: state_next = sra_pkg::ST_DONE;
            sra_pkg::ST_REP_GO:   state_next = sra_pkg::ST_REP_WAIT;
            sra_pkg::ST_REP_WAIT: begin
                if (sts.div_done) begin
                    state_next = sra_pkg::ST_OBS_GO;
                end
            end
            sra_pkg::ST_OBS_GO:   state_next = sra_pkg::ST_OBS_WAIT;
            sra_pkg::ST_OBS_WAIT: begin
                if (sts.div_done) begin
                    state_next = sra_pkg::ST_EXP_GO;
                end
            end
            sra_pkg::ST_EXP_GO: begin
                state_next = sts.obs_zero ? sra_pkg::ST_FIN_CHK : sra_pkg::ST_EXP_WAIT;
            end
            sra_pkg::ST_EXP_WAIT: begin
                if (sts.div_done) begin
                    state_next = sra_pkg::ST_WALK_RD;
                end
            end
            sra_pkg::ST_WALK_RD: begin
                state_next = sts.walk_more ? sra_pkg::ST_WALK_ACC : sra_pkg::ST_FIN_CHK;
            end
            sra_pkg::ST_WALK_ACC: state_next = sra_pkg::ST_WIN_CHK;
            sra_pkg::ST_WIN_CHK: begin
                if (sts.win_close && sts.win_ok && sts.win_any) begin
                    state_next = sra_pkg::ST_WIN_GO;
                end else begin
                    state_next = sra_pkg::ST_WALK_RD;
                end
            end
            sra_pkg::ST_WIN_GO:   state_next = sra_pkg::ST_WIN_WAIT;
            sra_pkg::ST_WIN_WAIT: begin
                if (sts.div_done) begin
                    state_next = sra_pkg::ST_WALK_RD;
                end
            end
            sra_pkg::ST_FIN_CHK: begin
                if (sts.fin_ok && sts.acc_any) begin
                    state_next = sra_pkg::ST_FIN_GO;
                end else begin
                    state_next = sra_pkg::ST_DONE;
                end
            end
            sra_pkg::ST_FIN_GO:   state_next = sra_pkg::ST_FIN_WAIT;
            sra_pkg::ST_FIN_WAIT: begin
                if (sts.div_done) begin
                    state_next = sra_pkg::ST_DONE;
                end
            end
            sra_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = sra_pkg::ST_IDLE;
                end
            end
            default: state_next = sra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.div_sel = sra_pkg::DSEL_REP;
        case (state_reg)
            sra_pkg::ST_IDLE:     ctl.in_ready = 1'b1;
            sra_pkg::ST_INST_RD:  ctl.rd_en = 1'b1;
            sra_pkg::ST_INST_SET: ctl.set_inst = 1'b1;
            sra_pkg::ST_REP_GO: begin
                ctl.div_sel   = sra_pkg::DSEL_REP;
                ctl.div_start = 1'b1;
            end
            sra_pkg::ST_REP_WAIT: begin
                ctl.div_sel   = sra_pkg::DSEL_REP;
                ctl.div_store = sts.div_done;
            end
            sra_pkg::ST_OBS_GO: begin
                ctl.div_sel   = sra_pkg::DSEL_OBS;
                ctl.div_start = 1'b1;
            end
            sra_pkg::ST_OBS_WAIT: begin
                ctl.div_sel   = sra_pkg::DSEL_OBS;
                ctl.div_store = sts.div_done;
            end
            sra_pkg::ST_EXP_GO: begin
                ctl.div_sel   = sra_pkg::DSEL_EXP;
                ctl.div_start = !sts.obs_zero;
            end
            sra_pkg::ST_EXP_WAIT: begin
                ctl.div_sel   = sra_pkg::DSEL_EXP;
                ctl.div_store = sts.div_done;
            end
            sra_pkg::ST_WALK_RD:  ctl.rd_en = sts.walk_more;
            sra_pkg::ST_WALK_ACC: ctl.acc = 1'b1;
            sra_pkg::ST_WIN_CHK: begin
                ctl.win_accept_zero = sts.win_close && sts.win_ok && !sts.win_any;
                ctl.win_reject      = sts.win_close && !sts.win_ok;
            end
            sra_pkg::ST_WIN_GO: begin
                ctl.div_sel   = sra_pkg::DSEL_WIN;
                ctl.div_start = 1'b1;
            end
            sra_pkg::ST_WIN_WAIT: begin
                ctl.div_sel         = sra_pkg::DSEL_WIN;
                ctl.win_accept_quot = sts.div_done;
            end
            sra_pkg::ST_FIN_CHK: begin
                ctl.set_valid_zero = sts.fin_ok && !sts.acc_any;
                ctl.set_invalid    = !sts.fin_ok;
            end
            sra_pkg::ST_FIN_GO: begin
                ctl.div_sel   = sra_pkg::DSEL_FIN;
                ctl.div_start = 1'b1;
            end
            sra_pkg::ST_FIN_WAIT: begin
                ctl.div_sel        = sra_pkg::DSEL_FIN;
                ctl.set_valid_quot = sts.div_done;
            end
            sra_pkg::ST_DONE:     ctl.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== design/sample_ring_report_aggregator.sv =====
// A push transaction leaves the block idle, and it is ready again in the next cycle.
// An instant report reads the newest sample into the result; ready again once the slot is loaded.
// A full report divides on the shared bit-serial divider (28-bit dividend by default) for the
// report, observation and (if observations are nonzero) expected counts, walks samples newest
// first, divides each accepted window with valid samples, then the final mean; one at a time.
// Synchronous active-low reset restores the registers and empties the ring.
// ----------------------------------------------------------------------------
// sample_ring_report_aggregator
// Stores samples in a ring and aggregates them into windowed reports.
// ----------------------------------------------------------------------------
module sample_ring_report_aggregator #(
    parameter int unsigned RING_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,  // cmd
    input  logic [47:0] s_tdata,  // sample_value, in_maintenance, report_seconds,
                                  // observation_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // mean_value, quality, report_valid
);

    sra_pkg::ctrl_cmd_t  ctl;
    sra_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;
    assign s_tready  = ctl.in_ready;

    sra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctl     (ctl)
    );

    sra_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
